FILE: src/sdb_pkg.sv
// ----------------------------------------------------------------------------
// sdb_pkg
// Shared widths, register codes and request types of the destination binner.
// ----------------------------------------------------------------------------
package sdb_pkg;

  localparam int NUM_SLOTS      = 4;
  localparam int WORDS_PER_SLOT = 8;

  localparam int DEST_W    = 24;
  localparam int DELAY_W   = 8;
  localparam int WEIGHT_W  = 32;
  localparam int SPAN_W    = 23;
  localparam int RID_W     = 4;
  localparam int WORD_BITS = DEST_W + DELAY_W + WEIGHT_W;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int WIDX_W    = $clog2(WORDS_PER_SLOT);
  localparam int FILL_W    = $clog2(WORDS_PER_SLOT + 1);
  localparam int TH_W      = SPAN_W + $clog2(NUM_SLOTS + 1) + 2;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [DEST_W-1:0] DEST_BASE_RST = DEST_W'(1);
  localparam logic [SPAN_W-1:0] DEST_SPAN_RST = SPAN_W'(2048);
  localparam logic [RID_W-1:0]  ROUTER_ID_RST = RID_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_BASE = 2'd0,
    REG_DEST_SPAN = 2'd1,
    REG_ROUTER_ID = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DEST_W-1:0] base;
    logic [SPAN_W-1:0] span;
  } cfg_t;

  // Classified input request handed from the front to the back.
  typedef struct packed {
    logic                 in_range;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_BITS-1:0] word;
    logic                 beat;
    logic                 fin;
  } cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [WIDX_W-1:0]    index;
    logic [SLOT_W-1:0]    slot;
    logic                 frame_last;
    logic                 run_last;
  } res_t;

endpackage

FILE: src/synapse_destination_binner.sv
// ----------------------------------------------------------------------------
// synapse_destination_binner
// Bins synapse entries into destination-range slots and emits full or flushed slots.
// ----------------------------------------------------------------------------
// Input side is a queue: present an entry and raise push; it is taken when
// full is low. The front compares the destination against the slot range
// thresholds (base + k*span) and drops the classified request into a
// four-deep request queue. The back takes one request per cycle while it is
// not emitting, so plain entries stream at one per cycle.
// A beat end with full slots, or a stream end, makes the back emit eight
// words per slot, one word per cycle while the result queue has room; the
// request queue keeps taking entries until it fills. A stream end always
// emits all four slots. Results wait in a four-deep queue: the oldest is on
// the ports while empty is low and leaves on pop. A stalled receiver fills
// that queue, then the back holds, then the request queue, and finally full
// rises. With both queues empty, an accepted request passes the request queue
// and the back's emit state before its first word reaches the result ports.
// Configuration writes are always ready and take effect on the next cycle.
// Reset clears the slot fill counts (all slots read as zero), both queues,
// and loads dest_base 1, dest_span 2048, router_id 3.
// ----------------------------------------------------------------------------
module synapse_destination_binner
  import sdb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // entry channel
  input  logic                  push,
  output logic                  full,
  input  logic [DEST_W-1:0]     dest_neuron,
  input  logic [DELAY_W-1:0]    delay_value,
  input  logic [WEIGHT_W-1:0]   weight_bits,
  input  logic                  beat_end,
  input  logic                  stream_end,
  // result channel
  output logic                  empty,
  input  logic                  pop,
  output logic [WORD_BITS-1:0]  slot_word,
  output logic [WIDX_W-1:0]     word_index,
  output logic [SLOT_W-1:0]     dest_slot,
  output logic [RID_W-1:0]      source_id,
  output logic                  frame_last,
  output logic                  run_last
);

  cfg_t             cfg;
  logic [RID_W-1:0] router_id;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_out;
  logic out_push;
  logic out_full;
  res_t res_in;
  res_t res_out;

  assign cfg_ready = 1'b1;

  // Decode register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base  <= DEST_BASE_RST;
      cfg.span  <= DEST_SPAN_RST;
      router_id <= ROUTER_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEST_BASE: cfg.base  <= cfg_data[DEST_W-1:0];
        REG_DEST_SPAN: cfg.span  <= cfg_data[SPAN_W-1:0];
        REG_ROUTER_ID: router_id <= cfg_data[RID_W-1:0];
        default: ;
      endcase
    end
  end

  sdb_front u_front (
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .dest_neuron (dest_neuron),
    .delay_value (delay_value),
    .weight_bits (weight_bits),
    .beat_end    (beat_end),
    .stream_end  (stream_end),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  sdb_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .data_in  (cmd_in),
    .full     (full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .data_out (cmd_out)
  );

  sdb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .res       (res_in)
  );

  sdb_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .data_in  (res_in),
    .full     (out_full),
    .pop      (pop),
    .empty    (empty),
    .data_out (res_out)
  );

  // Source id follows the register; user must rewrite it only while idle, unchecked.
  assign slot_word  = res_out.word;
  assign word_index = res_out.index;
  assign dest_slot  = res_out.slot;
  assign source_id  = router_id;
  assign frame_last = res_out.frame_last;
  assign run_last   = res_out.run_last;

endmodule

FILE: src/sdb_front.sv
// ----------------------------------------------------------------------------
// sdb_front
// Classifies an incoming synapse entry into a slot by destination range.
// ----------------------------------------------------------------------------
module sdb_front
  import sdb_pkg::*;
(
  input  cfg_t                 cfg,
  input  logic                 push,
  input  logic                 full,
  input  logic [DEST_W-1:0]    dest_neuron,
  input  logic [DELAY_W-1:0]   delay_value,
  input  logic [WEIGHT_W-1:0]  weight_bits,
  input  logic                 beat_end,
  input  logic                 stream_end,
  output logic                 cmd_push,
  output cmd_t                 cmd
);

  logic [TH_W-1:0]   dst_ext;
  logic [TH_W-1:0]   top_th;
  logic [SLOT_W-1:0] slot;

  // Threshold k is base + k*span; the slot is the count of passed thresholds.
  always_comb begin
    dst_ext = TH_W'(dest_neuron);
    top_th  = TH_W'(cfg.base) + TH_W'(NUM_SLOTS) * TH_W'(cfg.span);
    slot    = '0;
    for (int k = 1; k < NUM_SLOTS; k++) begin
      if (dst_ext >= TH_W'(cfg.base) + TH_W'(k) * TH_W'(cfg.span)) begin
        slot = SLOT_W'(k);
      end
    end
  end

  assign cmd_push     = push && !full;
  assign cmd.in_range = (cfg.span != '0) && (dest_neuron >= cfg.base) && (dst_ext < top_th);
  assign cmd.slot     = slot;
  assign cmd.word     = {dest_neuron, delay_value, weight_bits};
  assign cmd.beat     = beat_end;
  assign cmd.fin      = stream_end;

endmodule

FILE: src/sdb_cmd_queue.sv
// ----------------------------------------------------------------------------
// sdb_cmd_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module sdb_cmd_queue
  import sdb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t data_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t data_out
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem [CMD_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(CMD_DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign data_out = mem[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(CMD_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == PTR_W'(CMD_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/sdb_back.sv
// ----------------------------------------------------------------------------
// sdb_back
// Slot store and emit sequencer: stores entries, drains full slots and flushes.
// ----------------------------------------------------------------------------
module sdb_back
  import sdb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic out_full,
  output logic out_push,
  output res_t res
);

  localparam int STORE_DEPTH = NUM_SLOTS * WORDS_PER_SLOT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t               state;
  logic [WORD_BITS-1:0] store [STORE_DEPTH];
  logic [FILL_W-1:0]    fill  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mask;
  logic [WIDX_W-1:0]    widx;
  logic                 flast;

  logic                 do_store;
  logic [FILL_W-1:0]    tgt_fill;
  logic [NUM_SLOTS-1:0] full_now;
  logic [SLOT_W-1:0]    cur;
  logic [NUM_SLOTS-1:0] rest;
  logic                 last_word;
  logic [STORE_AW-1:0]  wr_idx;
  logic [STORE_AW-1:0]  rd_idx;
  logic                 fill_ok;

  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign tgt_fill  = fill[cmd.slot];
  assign do_store  = cmd_pop && !cmd.fin && cmd.in_range
                     && (tgt_fill < FILL_W'(WORDS_PER_SLOT));
  assign last_word = (widx == WIDX_W'(WORDS_PER_SLOT - 1));
  assign wr_idx    = STORE_AW'(STORE_AW'(cmd.slot) * STORE_AW'(WORDS_PER_SLOT)
                     + STORE_AW'(tgt_fill));
  assign rd_idx    = STORE_AW'(STORE_AW'(cur) * STORE_AW'(WORDS_PER_SLOT) + STORE_AW'(widx));

  always_comb begin
    full_now = '0;
    cur      = '0;
    rest     = '0;
    fill_ok  = 1'b1;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      full_now[s] = (fill[s] == FILL_W'(WORDS_PER_SLOT))
                    || (do_store && (cmd.slot == SLOT_W'(s))
                        && (fill[s] == FILL_W'(WORDS_PER_SLOT - 1)));
      if (fill[s] > FILL_W'(WORDS_PER_SLOT)) begin
        fill_ok = 1'b0;
      end
    end
    // Lowest pending slot goes first.
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        cur = SLOT_W'(s);
      end
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      rest[s] = mask[s] && (SLOT_W'(s) != cur);
    end
  end

  assign out_push       = (state == ST_EMIT) && !out_full;
  // Positions past the fill count read as zero, so a drained slot needs no clearing.
  assign res.word       = (FILL_W'(widx) < fill[cur]) ? store[rd_idx] : '0;
  assign res.index      = widx;
  assign res.slot       = cur;
  assign res.frame_last = flast;
  assign res.run_last   = last_word && (rest == '0);

  always_ff @(posedge clk) begin
    if (do_store) begin
      store[wr_idx] <= cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mask  <= '0;
      widx  <= '0;
      flast <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        fill[s] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (do_store) begin
            fill[cmd.slot] <= tgt_fill + FILL_W'(1);
          end
          if (cmd_pop) begin
            widx <= '0;
            if (cmd.fin) begin
              mask  <= '1;
              flast <= 1'b1;
              state <= ST_EMIT;
            end else if (cmd.beat && (full_now != '0)) begin
              mask  <= full_now;
              flast <= 1'b0;
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_push) begin
            if (last_word) begin
              widx      <= '0;
              fill[cur] <= '0;
              mask      <= rest;
              if (rest == '0) begin
                state <= ST_IDLE;
              end
            end else begin
              widx <= widx + WIDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill_ok)
    else $error("slot fill count above slot size");
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (mask != '0))
    else $error("emitting with no pending slot");
  a_run_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_push && res.run_last) |=> (state == ST_IDLE))
    else $error("run end marked but emission continues");
  a_no_pop_while_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !cmd_pop)
    else $error("request taken during emission");

endmodule

FILE: src/sdb_out_queue.sv
// ----------------------------------------------------------------------------
// sdb_out_queue
// Result queue that absorbs emit bursts and decouples the receiver's stalls.
// ----------------------------------------------------------------------------
module sdb_out_queue
  import sdb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t data_in,
  output logic full,
  input  logic pop,
  output logic empty,
  output res_t data_out
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  res_t             mem [OUT_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(OUT_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PTR_W'(OUT_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == PTR_W'(OUT_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the synapse destination binner.
// ----------------------------------------------------------------------------
// A table of directed requests runs first, then phases of random requests
// under several register settings. A bench-side binner mirrors the slot
// stores and builds the expected slot words for every accepted request.
// Each popped word is checked field by field against the oldest expected
// word. Both sides idle at random; one phase holds the receiver off long
// enough to back the block up until it raises full.
// ----------------------------------------------------------------------------
module tb_top;
  import sdb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PLAN_ROWS    = 25;

  // One entry request as the sender sees it.
  typedef struct packed {
    logic [DEST_W-1:0]   dest;
    logic [DELAY_W-1:0]  dly;
    logic [WEIGHT_W-1:0] wgt;
    logic                beat;
    logic                fin;
  } synapse_t;

  // One word leaving a slot, as seen on the result ports.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [WIDX_W-1:0]    index;
    logic [SLOT_W-1:0]    slot;
    logic [RID_W-1:0]     source;
    logic                 frame_last;
    logic                 run_last;
  } binned_word_t;

  // Directed row: typed marks rows whose words are all zero and can be
  // written down directly (n_words of them, slots in order).
  typedef struct packed {
    logic [DEST_W-1:0]   dest;
    logic [DELAY_W-1:0]  dly;
    logic [WEIGHT_W-1:0] wgt;
    logic                beat;
    logic                fin;
    logic                typed;
    logic [5:0]          n_words;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DEST_BASE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  push        = 1'b0;
  logic                  full;
  logic [DEST_W-1:0]     dest_neuron = '0;
  logic [DELAY_W-1:0]    delay_value = '0;
  logic [WEIGHT_W-1:0]   weight_bits = '0;
  logic                  beat_end    = 1'b0;
  logic                  stream_end  = 1'b0;

  logic                  empty;
  logic                  pop = 1'b0;
  logic [WORD_BITS-1:0]  slot_word;
  logic [WIDX_W-1:0]     word_index;
  logic [SLOT_W-1:0]     dest_slot;
  logic [RID_W-1:0]      source_id;
  logic                  frame_last;
  logic                  run_last;

  synapse_destination_binner i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .dest_neuron(dest_neuron),
    .delay_value(delay_value),
    .weight_bits(weight_bits),
    .beat_end   (beat_end),
    .stream_end (stream_end),
    .empty      (empty),
    .pop        (pop),
    .slot_word  (slot_word),
    .word_index (word_index),
    .dest_slot  (dest_slot),
    .source_id  (source_id),
    .frame_last (frame_last),
    .run_last   (run_last)
  );

  // 2 ns clock, one delay per half period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the block state and registers.
  logic [WORD_BITS-1:0] bin_words [NUM_SLOTS][WORDS_PER_SLOT];
  int                   bin_fill  [NUM_SLOTS];
  logic [DEST_W-1:0]    base_now = DEST_BASE_RST;
  logic [SPAN_W-1:0]    span_now = DEST_SPAN_RST;
  logic [RID_W-1:0]     rid_now  = ROUTER_ID_RST;

  binned_word_t words_due[$];    // expected words, oldest first
  binned_word_t fresh_words[$];  // words caused by the latest request

  int mismatches  = 0;
  int cycle_count = 0;
  int send_idle   = 0;  // percent of cycles the sender stays quiet
  int recv_stall  = 0;  // percent of cycles the receiver does not pop
  int hold_asked  = 0;  // bumped by the sender to start a long hold-off
  int hold_seen   = 0;
  int hold_left   = 0;

  // Directed requests under the reset registers: base 1, span 2048, so
  // slot 0 covers 1..2048, slot 1 2049..4096, slot 2 4097..6144 and
  // slot 3 6145..8192.
  plan_row_t plan [PLAN_ROWS] = '{
    // stream end straight after reset: four slots of zero words
    '{24'd0,        8'h00, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 6'd32},
    // below base, then far beyond the last slot: dropped, nothing out
    '{24'd0,        8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 6'd0},
    '{24'hFF_FFFF,  8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 6'd0},
    // both edges of slot 0, first of slot 1, last of slot 3
    '{24'd1,        8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd2048,     8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd2049,     8'h12, 32'h89AB_CDEF, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd8192,     8'h7F, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 6'd0},
    // beat end while no slot is full
    '{24'd4097,     8'h01, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 6'd0},
    // top slot 0 up to eight words
    '{24'd100,      8'h10, 32'h1111_1111, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd200,      8'h20, 32'h2222_2222, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd300,      8'h30, 32'h3333_3333, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd400,      8'h40, 32'h4444_4444, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd500,      8'h50, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd600,      8'h60, 32'h6666_6666, 1'b0, 1'b0, 1'b0, 6'd0},
    // slot 0 already full and no beat end yet: dropped
    '{24'd777,      8'hA5, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 6'd0},
    // beat end on a dropped entry still emits the full slot
    '{24'd0,        8'h5A, 32'hCAFE_F00D, 1'b1, 1'b0, 1'b0, 6'd0},
    // fill slot 3 to eight words with no beat end
    '{24'd6145,     8'h81, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6146,     8'h82, 32'h8000_0002, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6147,     8'h83, 32'h8000_0003, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6148,     8'h84, 32'h8000_0004, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6149,     8'h85, 32'h8000_0005, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6150,     8'h86, 32'h8000_0006, 1'b0, 1'b0, 1'b0, 6'd0},
    '{24'd6151,     8'h87, 32'h8000_0007, 1'b0, 1'b0, 1'b0, 6'd0},
    // stream end and beat end together, slot 3 full: one final flush only
    '{24'd6200,     8'hEE, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 6'd0},
    // stream end again: everything was cleared by the flush
    '{24'd9999,     8'h33, 32'h7777_7777, 1'b0, 1'b1, 1'b1, 6'd32}
  };

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Emit one slot into the fresh words and clear it.
  task automatic dump_slot(input int s, input logic last_flag);
    binned_word_t w;
    for (int i = 0; i < WORDS_PER_SLOT; i++) begin
      w = '{word: bin_words[s][i], index: WIDX_W'(i), slot: SLOT_W'(s),
            source: rid_now, frame_last: last_flag, run_last: 1'b0};
      fresh_words.push_back(w);
      bin_words[s][i] = '0;
    end
    bin_fill[s] = 0;
  endtask

  // Bin one accepted request and collect the words it releases.
  task automatic bin_entry(input synapse_t e);
    logic [63:0]  rel;
    int           k;
    binned_word_t tail;
    fresh_words.delete();
    if (e.fin) begin
      // stream end wins over beat end: flush every slot, empty ones too
      for (int s = 0; s < NUM_SLOTS; s++)
        dump_slot(s, 1'b1);
    end else begin
      // zero span covers nothing; below base is out of every range
      if (span_now != '0 && e.dest >= base_now) begin
        rel = (64'(e.dest) - 64'(base_now)) / 64'(span_now);
        if (rel < 64'(NUM_SLOTS)) begin
          k = int'(rel);
          // a full slot drops further entries until it is emptied
          if (bin_fill[k] < WORDS_PER_SLOT) begin
            bin_words[k][bin_fill[k]] = {e.dest, e.dly, e.wgt};
            bin_fill[k]++;
          end
        end
      end
      if (e.beat) begin
        for (int s = 0; s < NUM_SLOTS; s++)
          if (bin_fill[s] >= WORDS_PER_SLOT)
            dump_slot(s, 1'b0);
      end
    end
    // mark the last word caused by this request
    if (fresh_words.size() > 0) begin
      tail = fresh_words.pop_back();
      tail.run_last = 1'b1;
      fresh_words.push_back(tail);
    end
  endtask

  // Record an accepted request: typed rows state their own words.
  task automatic take_request(input synapse_t e, input logic typed, input int n_words);
    binned_word_t w;
    bin_entry(e);
    if (typed) begin
      fresh_words.delete();
      for (int i = 0; i < n_words; i++) begin
        w = '{word: '0, index: WIDX_W'(i % WORDS_PER_SLOT),
              slot: SLOT_W'(i / WORDS_PER_SLOT), source: rid_now,
              frame_last: e.fin, run_last: (i == n_words - 1)};
        fresh_words.push_back(w);
      end
    end
    foreach (fresh_words[i])
      words_due.push_back(fresh_words[i]);
  endtask

  // Offer one request; call and return at a falling edge. Expectations are
  // queued at the falling edge after the accepting edge so the checker at that
  // edge never sees them.
  task automatic offer(input synapse_t e, input logic typed, input int n_words);
    while ($urandom_range(0, 99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push        = 1'b1;
    dest_neuron = e.dest;
    delay_value = e.dly;
    weight_bits = e.wgt;
    beat_end    = e.beat;
    stream_end  = e.fin;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    take_request(e, typed, n_words);
  endtask

  // Random request: mostly in range of some slot, some below base or
  // anywhere, occasional beat ends and rarer stream ends.
  function automatic synapse_t rand_entry();
    synapse_t    e;
    int unsigned pick;
    logic [63:0] spot;
    pick   = $urandom_range(0, 9);
    e.dly  = DELAY_W'($urandom);
    e.wgt  = $urandom;
    e.beat = ($urandom_range(0, 5) == 0);
    e.fin  = ($urandom_range(0, 29) == 0);
    if (pick == 0 || span_now == '0) begin
      e.dest = DEST_W'($urandom);
    end else if (pick == 1 && base_now != '0) begin
      e.dest = DEST_W'($urandom_range(0, 32'(base_now) - 1));
    end else begin
      spot = 64'(base_now) + 64'($urandom_range(0, NUM_SLOTS - 1)) * 64'(span_now)
           + 64'($urandom % 32'(span_now));
      e.dest = spot[DEST_W-1:0];
    end
    return e;
  endfunction

  // Wait until every expected word is out, then let in-flight requests
  // that cause no words clear the pipe. Returns at a falling edge.
  task automatic settle();
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEST_BASE: base_now = val[DEST_W-1:0];
      REG_DEST_SPAN: span_now = val[SPAN_W-1:0];
      REG_ROUTER_ID: rid_now  = val[RID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [DEST_W-1:0] base, input logic [SPAN_W-1:0] span,
                          input logic [RID_W-1:0] rid);
    write_reg(REG_DEST_BASE, CFG_DATA_W'(base));
    write_reg(REG_DEST_SPAN, CFG_DATA_W'(span));
    write_reg(REG_ROUTER_ID, CFG_DATA_W'(rid));
  endtask

  task automatic run_phase(input int items, input int send_pct, input int stall_pct);
    send_idle  = send_pct;
    recv_stall = stall_pct;
    repeat (items) offer(rand_entry(), 1'b0, 0);
    push = 1'b0;
    settle();
  endtask

  // Receiver: pop at random, or hold off entirely while a long hold runs.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Check every popped word against the oldest expectation.
  always @(posedge clk) begin
    binned_word_t want;
    if (!rst && pop && !empty) begin
      if (words_due.size() == 0) begin
        flag_mismatch("word with none expected", slot_word, '0);
      end else begin
        want = words_due.pop_front();
        if (slot_word !== want.word)
          flag_mismatch("slot_word", slot_word, want.word);
        if (word_index !== want.index)
          flag_mismatch("word_index", 64'(word_index), 64'(want.index));
        if (dest_slot !== want.slot)
          flag_mismatch("dest_slot", 64'(dest_slot), 64'(want.slot));
        if (source_id !== want.source)
          flag_mismatch("source_id", 64'(source_id), 64'(want.source));
        if (frame_last !== want.frame_last)
          flag_mismatch("frame_last", 64'(frame_last), 64'(want.frame_last));
        if (run_last !== want.run_last)
          flag_mismatch("run_last", 64'(run_last), 64'(want.run_last));
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      bin_fill[s] = 0;
      for (int i = 0; i < WORDS_PER_SLOT; i++)
        bin_words[s][i] = '0;
    end

    // Hold reset, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table under the reset registers, no idling.
    for (int r = 0; r < PLAN_ROWS; r++)
      offer('{plan[r].dest, plan[r].dly, plan[r].wgt, plan[r].beat, plan[r].fin},
            plan[r].typed, int'(plan[r].n_words));
    push = 1'b0;
    settle();

    // Reset registers, no idling.
    run_phase(25, 0, 0);

    // Narrowest span from destination zero; sender idles.
    set_regs(24'd0, 23'd1, 4'd0);
    run_phase(25, 54, 0);

    // Slots packed against the top of the destination space; receiver stalls.
    set_regs(24'hFF_FFF0, 23'd3, 4'd15);
    run_phase(25, 0, 54);

    // Zero span: every entry is dropped, only stream ends produce words.
    set_regs(24'd1, 23'd0, 4'd5);
    run_phase(15, 27, 27);

    // Widest span the register holds.
    set_regs(24'd0, 23'h7F_FFFF, 4'd10);
    run_phase(25, 27, 27);

    // Back-pressure: hold the receiver off, lead with a stream end so the
    // 32-word flush fills the output side, and keep offering until full.
    set_regs(24'd1, 23'd4194304, 4'd3);
    send_idle  = 0;
    recv_stall = 0;
    hold_asked = hold_asked + 1;
    offer('{24'd0, 8'h00, 32'h0, 1'b0, 1'b1}, 1'b0, 0);
    repeat (30) offer(rand_entry(), 1'b0, 0);
    push = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
